@@ rtl/core/tcmg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcmg_pkg
// Shared types, command codes and constant tables of the cone mesh generator.
// ----------------------------------------------------------------------------
package tcmg_pkg;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_LOAD    = 4'd1,
        OP_POS     = 4'd2,
        OP_CROSS   = 4'd3,
        OP_ABS     = 4'd4,
        OP_SHIFT   = 4'd5,
        OP_SQ      = 4'd6,
        OP_SQRT    = 4'd7,
        OP_DIVINIT = 4'd8,
        OP_DIV     = 4'd9,
        OP_ZERO    = 4'd10,
        OP_EMIT    = 4'd11
    } t_op;

    // Normal source for an emitted vertex.
    typedef enum logic [1:0] {
        NSEL_SIDE = 2'd0,
        NSEL_DOWN = 2'd1,
        NSEL_UP   = 2'd2
    } t_nsel;

    typedef struct packed {
        t_op         op;
        logic [4:0]  step;
        logic [3:0]  seg_n;
        logic [3:0]  ang;
        logic        rad_top;
        logic        center;
        t_nsel       nsel;
        logic [3:0]  u_idx;
        logic        tex_v;
        logic [5:0]  vnum;
        logic        last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic zero;
    } t_stat;

    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
    localparam int TAB_ROWS = 8;
    localparam int TAB_MAX  = 10;
    localparam logic [3:0] MIN_SEGMENTS = 4'd3;

    localparam logic signed [15:0] COS_TAB [TAB_ROWS][TAB_MAX] = '{
        '{16384, -8192, -8192, 0, 0, 0, 0, 0, 0, 0},
        '{16384, 0, -16384, 0, 0, 0, 0, 0, 0, 0},
        '{16384, 5063, -13255, -13255, 5063, 0, 0, 0, 0, 0},
        '{16384, 8192, -8192, -16384, -8192, 8192, 0, 0, 0, 0},
        '{16384, 10215, -3646, -14761, -14761, -3646, 10215, 0, 0, 0},
        '{16384, 11585, 0, -11585, -16384, -11585, 0, 11585, 0, 0},
        '{16384, 12551, 2845, -8192, -15396, -15396, -8192, 2845, 12551, 0},
        '{16384, 13255, 5063, -5063, -13255, -16384, -13255, -5063, 5063, 13255}
    };

    localparam logic signed [15:0] SIN_TAB [TAB_ROWS][TAB_MAX] = '{
        '{0, 14189, -14189, 0, 0, 0, 0, 0, 0, 0},
        '{0, 16384, 0, -16384, 0, 0, 0, 0, 0, 0},
        '{0, 15582, 9630, -9630, -15582, 0, 0, 0, 0, 0},
        '{0, 14189, 14189, 0, -14189, -14189, 0, 0, 0, 0},
        '{0, 12810, 15973, 7109, -7109, -15973, -12810, 0, 0, 0},
        '{0, 11585, 16384, 11585, 0, -11585, -16384, -11585, 0, 0},
        '{0, 10531, 16135, 14189, 5604, -5604, -14189, -16135, -10531, 0},
        '{0, 9630, 15582, 15582, 9630, 0, -9630, -15582, -15582, -9630}
    };

    // Rounded segment fractions in Q1.14, one row per segment count.
    localparam logic [14:0] TEXU_TAB [TAB_ROWS][TAB_MAX+1] = '{
        '{0, 5461, 10923, 16384, 0, 0, 0, 0, 0, 0, 0},
        '{0, 4096, 8192, 12288, 16384, 0, 0, 0, 0, 0, 0},
        '{0, 3277, 6554, 9830, 13107, 16384, 0, 0, 0, 0, 0},
        '{0, 2731, 5461, 8192, 10923, 13653, 16384, 0, 0, 0, 0},
        '{0, 2341, 4681, 7022, 9362, 11703, 14043, 16384, 0, 0, 0},
        '{0, 2048, 4096, 6144, 8192, 10240, 12288, 14336, 16384, 0, 0},
        '{0, 1820, 3641, 5461, 7282, 9102, 10923, 12743, 14564, 16384, 0},
        '{0, 1638, 3277, 4915, 6554, 8192, 9830, 11469, 13107, 14746, 16384}
    };

endpackage

@@ rtl/core/tcmg_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcmg_ctrl
// Sequencer: holds the segment count, walks segments, normal steps and the
// vertex run, and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module tcmg_ctrl #(
    parameter int MAX_SEGMENTS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [3:0]       i_cfg_data,
    input  tcmg_pkg::t_stat  i_stat,
    output tcmg_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] MAX_N = 4'(MAX_SEGMENTS);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_POS   = 8'b0000_0010,
        ST_CROSS = 8'b0000_0100,
        ST_NORM  = 8'b0000_1000,
        ST_SQ    = 8'b0001_0000,
        ST_SQRT  = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_cfg;
    logic [3:0] r_n, n_n;
    logic [3:0] r_seg, n_seg;
    logic [4:0] r_step, n_step;
    logic [5:0] r_vnum, n_vnum;
    logic       r_cap, n_cap;

    logic [3:0] seg_next, seg_j, n_clamped;
    logic [4:0] n5, cap_last;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);

    always_comb begin
        if (r_cfg < tcmg_pkg::MIN_SEGMENTS) begin
            n_clamped = tcmg_pkg::MIN_SEGMENTS;
        end else if (r_cfg > MAX_N) begin
            n_clamped = MAX_N;
        end else begin
            n_clamped = r_cfg;
        end
    end

    assign seg_next = r_seg + 4'd1;
    assign seg_j    = (seg_next == r_n) ? 4'd0 : seg_next;
    assign n5       = {1'b0, r_n};
    assign cap_last = {r_n, 1'b1};

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_seg   = r_seg;
        n_step  = r_step;
        n_vnum  = r_vnum;
        n_cap   = r_cap;
        o_cmd   = '0;
        o_cmd.op    = tcmg_pkg::OP_NONE;
        o_cmd.step  = r_step;
        o_cmd.seg_n = r_n;
        o_cmd.vnum  = r_vnum;
        o_cmd.nsel  = tcmg_pkg::NSEL_SIDE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = tcmg_pkg::OP_LOAD;
                    n_n      = n_clamped;
                    n_seg    = 4'd0;
                    n_step   = 5'd0;
                    n_vnum   = 6'd0;
                    n_cap    = 1'b0;
                    n_state  = ST_POS;
                end
            end
            ST_POS: begin
                o_cmd.op      = tcmg_pkg::OP_POS;
                o_cmd.ang     = (r_step == 5'd1) ? seg_j : r_seg;
                o_cmd.rad_top = (r_step == 5'd2);
                if (r_step == 5'd2) begin
                    n_step  = 5'd0;
                    n_state = ST_CROSS;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            ST_CROSS: begin
                o_cmd.op = tcmg_pkg::OP_CROSS;
                if (r_step == 5'd3) begin
                    n_step  = 5'd0;
                    n_state = ST_NORM;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            ST_NORM: begin
                if (r_step == 5'd0) begin
                    o_cmd.op = tcmg_pkg::OP_ABS;
                    n_step   = 5'd1;
                end else if (r_step == 5'd1 && i_stat.zero) begin
                    // A degenerate face skips straight to its vertices.
                    o_cmd.op = tcmg_pkg::OP_ZERO;
                    n_step   = 5'd0;
                    n_state  = ST_EMIT;
                end else begin
                    o_cmd.op = tcmg_pkg::OP_SHIFT;
                    if (r_step == 5'd6) begin
                        n_step  = 5'd0;
                        n_state = ST_SQ;
                    end else begin
                        n_step = r_step + 5'd1;
                    end
                end
            end
            ST_SQ: begin
                o_cmd.op = tcmg_pkg::OP_SQ;
                if (r_step == 5'd2) begin
                    n_step  = 5'd0;
                    n_state = ST_SQRT;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            ST_SQRT: begin
                o_cmd.op = tcmg_pkg::OP_SQRT;
                if (r_step == 5'd31) begin
                    n_step  = 5'd0;
                    n_state = ST_DIV;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            ST_DIV: begin
                o_cmd.op = (r_step == 5'd0) ? tcmg_pkg::OP_DIVINIT : tcmg_pkg::OP_DIV;
                if (r_step == 5'd15) begin
                    n_step  = 5'd0;
                    n_state = ST_EMIT;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            ST_EMIT: begin
                o_cmd.op = tcmg_pkg::OP_EMIT;
                if (!r_cap) begin
                    // Side quad: bottom i, bottom i+1, top i, top i+1.
                    o_cmd.ang     = r_step[0] ? seg_j : r_seg;
                    o_cmd.rad_top = r_step[1];
                    o_cmd.tex_v   = r_step[1];
                    o_cmd.u_idx   = r_step[0] ? seg_next : r_seg;
                    o_cmd.nsel    = tcmg_pkg::NSEL_SIDE;
                end else if (r_step <= n5) begin
                    o_cmd.center  = (r_step == 5'd0);
                    o_cmd.ang     = (r_step == 5'd0) ? 4'd0 : 4'(r_step - 5'd1);
                    o_cmd.nsel    = tcmg_pkg::NSEL_DOWN;
                end else begin
                    o_cmd.center  = (r_step == n5 + 5'd1);
                    o_cmd.ang     = (r_step == n5 + 5'd1) ? 4'd0 : 4'(r_step - n5 - 5'd2);
                    o_cmd.rad_top = 1'b1;
                    o_cmd.nsel    = tcmg_pkg::NSEL_UP;
                end
                o_cmd.last = r_cap && (r_step == cap_last);
                if (i_stat.out_free) begin
                    n_vnum = r_vnum + 6'd1;
                    n_step = r_step + 5'd1;
                    if (!r_cap && r_step == 5'd3) begin
                        n_step = 5'd0;
                        if (seg_next == r_n) begin
                            n_cap = 1'b1;
                        end else begin
                            n_seg   = seg_next;
                            n_state = ST_POS;
                        end
                    end else if (r_cap && r_step == cap_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cfg   <= 4'd8;
            r_n     <= 4'd8;
            r_seg   <= 4'd0;
            r_step  <= 5'd0;
            r_vnum  <= 6'd0;
            r_cap   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_seg   <= n_seg;
            r_step  <= n_step;
            r_vnum  <= n_vnum;
            r_cap   <= n_cap;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

endmodule

@@ rtl/core/tcmg_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcmg_dp
// Datapath: rim positions, cross product, normalizing shifter, bitwise square
// root, three-lane restoring divider and the output word register.
// ----------------------------------------------------------------------------
module tcmg_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcmg_pkg::t_cmd      i_cmd,
    output tcmg_pkg::t_stat     o_stat,
    input  logic [15:0]         i_cone_height,
    input  logic [15:0]         i_bottom_radius,
    input  logic [15:0]         i_top_radius,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_last_vertex,
    output logic [5:0]          o_vertex_number,
    output logic signed [16:0]  o_pos_x,
    output logic [15:0]         o_pos_y,
    output logic signed [16:0]  o_pos_z,
    output logic signed [15:0]  o_norm_x,
    output logic signed [15:0]  o_norm_y,
    output logic signed [15:0]  o_norm_z,
    output logic [14:0]         o_tex_u,
    output logic                o_tex_v
);

    logic [15:0] r_h, r_rb, r_rt;
    logic signed [16:0] r_x1, r_z1, r_x2, r_z2, r_x3, r_z3;
    logic signed [36:0] r_c [3];
    logic [35:0] r_a [3];
    logic        r_sgn [3];
    logic [63:0] r_acc, r_s, r_res, r_bit;
    logic [31:0] r_rem [3];
    logic [14:0] r_dsh [3];
    logic [14:0] r_quo [3];
    logic        r_out_valid;

    logic [2:0]  row;
    logic [3:0]  tmp_row;
    logic [15:0] rad;
    logic signed [15:0] cv, sv;
    logic signed [16:0] px, pz;
    logic        out_free;

    // Radius times a Q1.14 trig value, rounded half away from zero.
    function automatic logic signed [16:0] scale(input logic [15:0] r,
                                                 input logic signed [15:0] t);
        logic [14:0] mag;
        logic [30:0] p;
        logic [16:0] q;
        mag = t[15] ? 15'(-t) : t[14:0];
        p   = 31'(r * mag) + 31'd8192;
        q   = p[30:14];
        return t[15] ? -$signed(q) : $signed(q);
    endfunction

    assign tmp_row = i_cmd.seg_n - tcmg_pkg::MIN_SEGMENTS;
    assign row     = tmp_row[2:0];
    assign rad     = i_cmd.rad_top ? r_rt : r_rb;
    assign cv      = tcmg_pkg::COS_TAB[row][i_cmd.ang];
    assign sv      = tcmg_pkg::SIN_TAB[row][i_cmd.ang];
    assign px      = scale(rad, cv);
    assign pz      = scale(rad, sv);

    assign out_free        = !r_out_valid || i_out_ready;
    assign o_stat.out_free = out_free;
    assign o_stat.zero     = ((r_a[0] | r_a[1] | r_a[2]) == 36'd0);
    assign o_out_valid     = r_out_valid;

    // Cross product operands, one product per cycle.
    logic signed [17:0] ax, az, bx, bz, hs, m_a, m_b;
    logic signed [35:0] prod;
    assign ax = 18'(r_x3) - 18'(r_x1);
    assign az = 18'(r_z3) - 18'(r_z1);
    assign bx = 18'(r_x2) - 18'(r_x1);
    assign bz = 18'(r_z2) - 18'(r_z1);
    assign hs = $signed({2'b00, r_h});

    always_comb begin
        case (i_cmd.step[1:0])
            2'd0:    begin m_a = hs; m_b = bz; end
            2'd1:    begin m_a = hs; m_b = bx; end
            2'd2:    begin m_a = az; m_b = bx; end
            default: begin m_a = ax; m_b = bz; end
        endcase
    end
    assign prod = m_a * m_b;

    // Normalizing shift: left by 32, 16, 8, 4, 2, 1 while the top bits are clear.
    logic [35:0] any_a;
    logic [5:0]  sh_amt;
    logic        sh_do;
    assign any_a = r_a[0] | r_a[1] | r_a[2];
    always_comb begin
        case (i_cmd.step[2:0])
            3'd1:    sh_amt = 6'd32;
            3'd2:    sh_amt = 6'd16;
            3'd3:    sh_amt = 6'd8;
            3'd4:    sh_amt = 6'd4;
            3'd5:    sh_amt = 6'd2;
            default: sh_amt = 6'd1;
        endcase
        sh_do = ((any_a >> (6'd36 - sh_amt)) == 36'd0);
    end

    logic [30:0] sq_op;
    logic [61:0] sq;
    always_comb begin
        case (i_cmd.step[1:0])
            2'd0:    sq_op = r_a[0][35:5];
            2'd1:    sq_op = r_a[1][35:5];
            default: sq_op = r_a[2][35:5];
        endcase
    end
    assign sq = sq_op * sq_op;

    logic [63:0] s_cur, res_cur, bit_cur, trial;
    assign s_cur   = (i_cmd.step == 5'd0) ? r_acc : r_s;
    assign res_cur = (i_cmd.step == 5'd0) ? 64'd0 : r_res;
    assign bit_cur = (i_cmd.step == 5'd0) ? (64'd1 << 62) : r_bit;
    assign trial   = res_cur + bit_cur;

    logic [31:0] q;
    assign q = r_res[31:0];

    always_ff @(posedge i_clk) begin
        logic [45:0] d;
        logic [32:0] t;
        unique case (i_cmd.op)
            tcmg_pkg::OP_LOAD: begin
                r_h  <= i_cone_height;
                r_rb <= i_bottom_radius;
                r_rt <= i_top_radius;
            end
            tcmg_pkg::OP_POS: begin
                case (i_cmd.step[1:0])
                    2'd0:    begin r_x1 <= px; r_z1 <= pz; end
                    2'd1:    begin r_x2 <= px; r_z2 <= pz; end
                    default: begin r_x3 <= px; r_z3 <= pz; end
                endcase
            end
            tcmg_pkg::OP_CROSS: begin
                case (i_cmd.step[1:0])
                    2'd0:    r_c[0] <= 37'(prod);
                    2'd1:    r_c[2] <= -37'(prod);
                    2'd2:    r_c[1] <= 37'(prod);
                    default: r_c[1] <= r_c[1] - 37'(prod);
                endcase
            end
            tcmg_pkg::OP_ABS: begin
                for (int k = 0; k < 3; k++) begin
                    r_sgn[k] <= r_c[k][36];
                    r_a[k]   <= r_c[k][36] ? 36'(-r_c[k]) : r_c[k][35:0];
                end
            end
            tcmg_pkg::OP_SHIFT: begin
                if (sh_do) begin
                    for (int k = 0; k < 3; k++) begin
                        r_a[k] <= r_a[k] << sh_amt;
                    end
                end
            end
            tcmg_pkg::OP_SQ: begin
                r_acc <= ((i_cmd.step == 5'd0) ? 64'd0 : r_acc) + 64'(sq);
            end
            tcmg_pkg::OP_SQRT: begin
                if (s_cur >= trial) begin
                    r_s   <= s_cur - trial;
                    r_res <= (res_cur >> 1) + bit_cur;
                end else begin
                    r_s   <= s_cur;
                    r_res <= res_cur >> 1;
                end
                r_bit <= bit_cur >> 2;
            end
            tcmg_pkg::OP_DIVINIT: begin
                for (int k = 0; k < 3; k++) begin
                    d = {r_a[k][35:5], 14'b0} + 46'(q >> 1);
                    r_rem[k] <= {1'b0, d[45:15]};
                    r_dsh[k] <= d[14:0];
                    r_quo[k] <= 15'd0;
                end
            end
            tcmg_pkg::OP_DIV: begin
                for (int k = 0; k < 3; k++) begin
                    t = {r_rem[k], r_dsh[k][14]};
                    if (t >= {1'b0, q}) begin
                        r_rem[k] <= 32'(t - {1'b0, q});
                        r_quo[k] <= {r_quo[k][13:0], 1'b1};
                    end else begin
                        r_rem[k] <= t[31:0];
                        r_quo[k] <= {r_quo[k][13:0], 1'b0};
                    end
                    r_dsh[k] <= {r_dsh[k][13:0], 1'b0};
                end
            end
            tcmg_pkg::OP_ZERO: begin
                for (int k = 0; k < 3; k++) begin
                    r_quo[k] <= 15'd0;
                end
            end
            default: begin
            end
        endcase
    end

    logic signed [15:0] side_n [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            side_n[k] = r_sgn[k] ? -$signed({1'b0, r_quo[k]}) : $signed({1'b0, r_quo[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == tcmg_pkg::OP_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == tcmg_pkg::OP_EMIT && out_free) begin
            o_last_vertex   <= i_cmd.last;
            o_vertex_number <= i_cmd.vnum;
            o_pos_x         <= i_cmd.center ? 17'sd0 : px;
            o_pos_z         <= i_cmd.center ? 17'sd0 : pz;
            o_pos_y         <= i_cmd.rad_top ? r_h : 16'd0;
            o_tex_v         <= i_cmd.tex_v;
            case (i_cmd.nsel)
                tcmg_pkg::NSEL_SIDE: begin
                    o_norm_x <= side_n[0];
                    o_norm_y <= side_n[1];
                    o_norm_z <= side_n[2];
                    o_tex_u  <= tcmg_pkg::TEXU_TAB[row][i_cmd.u_idx];
                end
                tcmg_pkg::NSEL_DOWN: begin
                    o_norm_x <= 16'sd0;
                    o_norm_y <= -tcmg_pkg::ONE_Q14;
                    o_norm_z <= 16'sd0;
                    o_tex_u  <= 15'd0;
                end
                default: begin
                    o_norm_x <= 16'sd0;
                    o_norm_y <= tcmg_pkg::ONE_Q14;
                    o_norm_z <= 16'sd0;
                    o_tex_u  <= 15'd0;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/truncated_cone_mesh_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// truncated_cone_mesh_generator
// Turns one cone request into its 6N+2 vertex words: side quads, then caps.
// ----------------------------------------------------------------------------
// One cone word is taken at a time; the next is accepted once the last vertex
// word of the current cone sits in the output register. For each of the N
// segments the shared face normal is worked out in steps (rim positions, cross
// product, magnitude, normalizing shift, square-sum, square root at one bit per
// cycle, and divide), followed by its four vertex words; a degenerate face skips
// from the magnitude step straight to its vertices. The 2N+2 cap words then go
// out one per cycle while the output register is free. The segment count
// register is written through its own channel.
module truncated_cone_mesh_generator #(
    parameter int MAX_SEGMENTS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [3:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [15:0]         i_cone_height,
    input  logic [15:0]         i_bottom_radius,
    input  logic [15:0]         i_top_radius,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_last_vertex,
    output logic [5:0]          o_vertex_number,
    output logic signed [16:0]  o_pos_x,
    output logic [15:0]         o_pos_y,
    output logic signed [16:0]  o_pos_z,
    output logic signed [15:0]  o_norm_x,
    output logic signed [15:0]  o_norm_y,
    output logic signed [15:0]  o_norm_z,
    output logic [14:0]         o_tex_u,
    output logic                o_tex_v
);

    tcmg_pkg::t_cmd  cmd;
    tcmg_pkg::t_stat stat;

    tcmg_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tcmg_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cone_height   (i_cone_height),
        .i_bottom_radius (i_bottom_radius),
        .i_top_radius    (i_top_radius),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_last_vertex   (o_last_vertex),
        .o_vertex_number (o_vertex_number),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_pos_z         (o_pos_z),
        .o_norm_x        (o_norm_x),
        .o_norm_y        (o_norm_y),
        .o_norm_z        (o_norm_z),
        .o_tex_u         (o_tex_u),
        .o_tex_v         (o_tex_v)
    );

endmodule
